@@ src/jptl_pkg.sv @@
// shared types and constants of the joint pd trajectory limiter
package jptl_pkg;

    localparam int GOAL_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int WRAP_W    = 36;
    localparam int WRAP_K_W  = 4;
    localparam logic [WRAP_K_W-1:0] WRAP_K_TOP = 4'd15;

    localparam logic signed [WRAP_W-1:0] PI_Q16   = 36'sd205887;
    localparam logic signed [WRAP_W-1:0] TURN_Q16 = 36'sd411774;
    // a multiple of the full turn that makes goal minus position non-negative
    localparam logic signed [WRAP_W-1:0] TURN_BIAS = 36'sd13493010432;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 3'd5;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_CAPTURE = 4'd1,
        OP_LOAD    = 4'd2,
        OP_WRAP    = 4'd3,
        OP_KP      = 4'd4,
        OP_KD      = 4'd5,
        OP_DAMP    = 4'd6,
        OP_ACC     = 4'd7,
        OP_DV      = 4'd8,
        OP_VEL     = 4'd9,
        OP_DP      = 4'd10,
        OP_POS     = 4'd11,
        OP_PUBLISH = 4'd12
    } dp_op_t;

    typedef struct packed {
        dp_op_t                op;
        logic [WRAP_K_W-1:0]   wrap_k;
    } dp_cmd_t;

endpackage

@@ src/jptl_datapath.sv @@
// datapath: joint state, config registers, angle wrap and shared multiplier
module jptl_datapath #(
    parameter int NUM_JOINTS = 5,
    parameter int JW = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  jptl_pkg::dp_cmd_t                    cmd,
    input  logic [JW-1:0]                        joint,
    input  logic [jptl_pkg::GOAL_W*NUM_JOINTS-1:0] goal_bus,
    input  logic                                 cfg_valid,
    input  logic [jptl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jptl_pkg::CFG_DAT_W-1:0]       cfg_data,
    output logic [jptl_pkg::GOAL_W*NUM_JOINTS-1:0] pos_bus
);

    logic signed [31:0] goal_reg [NUM_JOINTS];
    logic signed [31:0] pos_reg  [NUM_JOINTS];
    logic signed [31:0] vel_reg  [NUM_JOINTS];
    logic signed [31:0] out_reg  [NUM_JOINTS];

    logic [26:0] prop_gain_reg;
    logic [26:0] deriv_gain_reg;
    logic [24:0] accel_limit_reg;
    logic [24:0] vel_limit_reg;
    logic [20:0] damping_reg;
    logic [15:0] step_time_reg;

    logic [jptl_pkg::WRAP_W-1:0] r_reg;
    logic signed [60:0] prod_reg;
    logic signed [63:0] sum_reg;
    logic signed [32:0] diff_reg;
    logic signed [31:0] nvel_reg;

    logic signed [31:0] goal_cur, pos_cur, vel_cur;
    logic signed [jptl_pkg::WRAP_W-1:0] load_val;
    logic [jptl_pkg::WRAP_W-1:0] turn_k;
    logic signed [19:0] err;
    logic signed [27:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [60:0] mul_p;
    logic signed [63:0] prod_ext;
    logic signed [47:0] acc_sh, alim48;
    logic signed [25:0] acc_cl;
    logic signed [39:0] vsum, vlim40, npos40;
    logic signed [31:0] vel_new, npos_sat;

    assign goal_cur = goal_reg[joint];
    assign pos_cur  = pos_reg[joint];
    assign vel_cur  = vel_reg[joint];

    assign load_val = {{4{goal_cur[31]}}, goal_cur} - {{4{pos_cur[31]}}, pos_cur}
                      + jptl_pkg::PI_Q16 + jptl_pkg::TURN_BIAS;
    assign turn_k   = jptl_pkg::TURN_Q16 << cmd.wrap_k;
    assign err      = $signed({1'b0, r_reg[18:0]}) - 20'sd205887;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            jptl_pkg::OP_KP: begin
                mul_a = {1'b0, prop_gain_reg};
                mul_b = {{13{err[19]}}, err};
            end
            jptl_pkg::OP_KD: begin
                mul_a = {1'b0, deriv_gain_reg};
                mul_b = {vel_cur[31], vel_cur};
            end
            jptl_pkg::OP_DAMP: begin
                mul_a = {7'b0, damping_reg};
                mul_b = {vel_cur[31], vel_cur};
            end
            jptl_pkg::OP_DV: begin
                mul_a = {12'b0, step_time_reg};
                mul_b = diff_reg;
            end
            jptl_pkg::OP_DP: begin
                mul_a = {12'b0, step_time_reg};
                mul_b = {vel_cur[31], vel_cur} + {nvel_reg[31], nvel_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{3{prod_reg[60]}}, prod_reg};

    assign acc_sh = sum_reg[63:16];
    assign alim48 = {23'b0, accel_limit_reg};
    always_comb begin
        if (acc_sh > alim48) begin
            acc_cl = {1'b0, accel_limit_reg};
        end else if (acc_sh < -alim48) begin
            acc_cl = -$signed({1'b0, accel_limit_reg});
        end else begin
            acc_cl = acc_sh[25:0];
        end
    end

    assign vsum   = {{8{vel_cur[31]}}, vel_cur} + prod_reg[55:16];
    assign vlim40 = {15'b0, vel_limit_reg};
    always_comb begin
        if (vsum > vlim40) begin
            vel_new = {7'b0, vel_limit_reg};
        end else if (vsum < -vlim40) begin
            vel_new = -$signed({7'b0, vel_limit_reg});
        end else begin
            vel_new = vsum[31:0];
        end
    end

    assign npos40 = {{8{pos_cur[31]}}, pos_cur} + prod_reg[56:17];
    always_comb begin
        if (npos40 > 40'sd2147483647) begin
            npos_sat = 32'sh7fffffff;
        end else if (npos40 < -40'sd2147483648) begin
            npos_sat = 32'sh80000000;
        end else begin
            npos_sat = npos40[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= 27'd6553600;
            deriv_gain_reg  <= 27'd3276800;
            accel_limit_reg <= 25'd98304;
            vel_limit_reg   <= 25'd98304;
            damping_reg     <= 21'd49152;
            step_time_reg   <= 16'd655;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                jptl_pkg::CFG_PROP_GAIN:   prop_gain_reg   <= cfg_data[26:0];
                jptl_pkg::CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[26:0];
                jptl_pkg::CFG_ACCEL_LIMIT: accel_limit_reg <= cfg_data[24:0];
                jptl_pkg::CFG_VEL_LIMIT:   vel_limit_reg   <= cfg_data[24:0];
                jptl_pkg::CFG_DAMPING:     damping_reg     <= cfg_data[20:0];
                jptl_pkg::CFG_STEP_TIME:   step_time_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_JOINTS; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end else if (cmd.op == jptl_pkg::OP_POS) begin
            pos_reg[joint] <= npos_sat;
            vel_reg[joint] <= nvel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            jptl_pkg::OP_CAPTURE: begin
                for (int i = 0; i < NUM_JOINTS; i++) begin
                    goal_reg[i] <= goal_bus[i*jptl_pkg::GOAL_W +: jptl_pkg::GOAL_W];
                end
            end
            jptl_pkg::OP_LOAD: r_reg <= load_val;
            jptl_pkg::OP_WRAP: begin
                if (r_reg >= turn_k) begin
                    r_reg <= r_reg - turn_k;
                end
            end
            jptl_pkg::OP_KP:   prod_reg <= mul_p;
            jptl_pkg::OP_KD: begin
                prod_reg <= mul_p;
                sum_reg  <= prod_ext;
            end
            jptl_pkg::OP_DAMP: begin
                prod_reg <= mul_p;
                sum_reg  <= sum_reg - prod_ext;
            end
            jptl_pkg::OP_ACC:  diff_reg <= {{7{acc_cl[25]}}, acc_cl} - prod_reg[48:16];
            jptl_pkg::OP_DV:   prod_reg <= mul_p;
            jptl_pkg::OP_VEL:  nvel_reg <= vel_new;
            jptl_pkg::OP_DP:   prod_reg <= mul_p;
            jptl_pkg::OP_PUBLISH: begin
                for (int i = 0; i < NUM_JOINTS; i++) begin
                    out_reg[i] <= pos_reg[i];
                end
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < NUM_JOINTS; g++) begin : g_out
        assign pos_bus[g*jptl_pkg::GOAL_W +: jptl_pkg::GOAL_W] = out_reg[g];
    end

endmodule

@@ src/jptl_ctrl.sv @@
// controller: sequences wrap, multiply and update steps joint by joint
module jptl_ctrl #(
    parameter int NUM_JOINTS = 5,
    parameter int JW = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output jptl_pkg::dp_cmd_t cmd,
    output logic [JW-1:0]     joint
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_LOAD = 12'b000000000010,
        S_WRAP = 12'b000000000100,
        S_KP   = 12'b000000001000,
        S_KD   = 12'b000000010000,
        S_DAMP = 12'b000000100000,
        S_ACC  = 12'b000001000000,
        S_DV   = 12'b000010000000,
        S_VEL  = 12'b000100000000,
        S_DP   = 12'b001000000000,
        S_POS  = 12'b010000000000,
        S_DONE = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [JW-1:0] joint_reg, joint_next;
    logic [jptl_pkg::WRAP_K_W-1:0] wrap_k_reg, wrap_k_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic last_joint, out_free;

    assign last_joint = (joint_reg == JW'(NUM_JOINTS - 1));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign joint      = joint_reg;

    always_comb begin
        state_next    = state_reg;
        joint_next    = joint_reg;
        wrap_k_next   = wrap_k_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = jptl_pkg::OP_NONE;
        cmd.wrap_k    = wrap_k_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = jptl_pkg::OP_CAPTURE;
                    joint_next = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.op      = jptl_pkg::OP_LOAD;
                wrap_k_next = jptl_pkg::WRAP_K_TOP;
                state_next  = S_WRAP;
            end
            S_WRAP: begin
                cmd.op = jptl_pkg::OP_WRAP;
                if (wrap_k_reg == '0) begin
                    state_next = S_KP;
                end else begin
                    wrap_k_next = wrap_k_reg - 1'b1;
                end
            end
            S_KP: begin
                cmd.op     = jptl_pkg::OP_KP;
                state_next = S_KD;
            end
            S_KD: begin
                cmd.op     = jptl_pkg::OP_KD;
                state_next = S_DAMP;
            end
            S_DAMP: begin
                cmd.op     = jptl_pkg::OP_DAMP;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op     = jptl_pkg::OP_ACC;
                state_next = S_DV;
            end
            S_DV: begin
                cmd.op     = jptl_pkg::OP_DV;
                state_next = S_VEL;
            end
            S_VEL: begin
                cmd.op     = jptl_pkg::OP_VEL;
                state_next = S_DP;
            end
            S_DP: begin
                cmd.op     = jptl_pkg::OP_DP;
                state_next = S_POS;
            end
            S_POS: begin
                cmd.op = jptl_pkg::OP_POS;
                if (last_joint) begin
                    state_next = S_DONE;
                end else begin
                    joint_next = joint_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.op        = jptl_pkg::OP_PUBLISH;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            joint_reg    <= '0;
            wrap_k_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            joint_reg    <= joint_next;
            wrap_k_reg   <= wrap_k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_LOAD && joint_reg == '0))
        else $error("accepted request did not start at the first joint");

    a_joint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        joint_reg <= JW'(NUM_JOINTS - 1))
        else $error("joint counter out of range");

    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == jptl_pkg::OP_PUBLISH) |-> out_free)
        else $error("result overwritten while still pending");

    a_wrap_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_KP) |-> $past(state_reg == S_WRAP && wrap_k_reg == '0))
        else $error("multiply started before angle wrap finished");

endmodule

@@ src/joint_pd_trajectory_limiter.sv @@
// top level: joint pd trajectory limiter with stream ports and config channel
// a request is accepted only in idle; m_tvalid rises when the last joint's result is published
// each joint takes 1 load, 16 angle-wrap subtract steps and 8 multiply and update steps
// a new request can be taken while the previous result still waits for m_tready
// reset: synchronous active-low aresetn zeroes positions and velocities, loads default gains
module joint_pd_trajectory_limiter #(
    parameter int NUM_JOINTS = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // goal_joint_a .. goal_joint_e, 32 bits each, from the lowest bit up
    input  logic [32*NUM_JOINTS-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // next_pos_a .. next_pos_e, 32 bits each, from the lowest bit up
    output logic [32*NUM_JOINTS-1:0]   m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [31:0]                cfg_data
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    jptl_pkg::dp_cmd_t cmd;
    logic [JW-1:0] joint;

    assign cfg_ready = 1'b1;

    jptl_ctrl #(
        .NUM_JOINTS(NUM_JOINTS),
        .JW(JW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .joint    (joint)
    );

    jptl_datapath #(
        .NUM_JOINTS(NUM_JOINTS),
        .JW(JW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .joint     (joint),
        .goal_bus  (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos_bus   (m_tdata)
    );

endmodule
